@@ design/tick_slot_operation_scheduler_macros.svh @@
// ----------------------------------------------------------------------------
// tick slot operation scheduler assertion macros
// concurrent assertion wrappers clocked on i_clk, TSOS_ASSERT gated by i_rst_n
// ----------------------------------------------------------------------------
`ifndef TICK_SLOT_OPERATION_SCHEDULER_MACROS_SVH
`define TICK_SLOT_OPERATION_SCHEDULER_MACROS_SVH

// assertion disabled while reset is active
`define TSOS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// assertion checked in every cycle, reset included
`define TSOS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ design/tsos_pkg.sv @@
// ----------------------------------------------------------------------------
// tsos_pkg
// shared types and constants of the tick slot operation scheduler
// ----------------------------------------------------------------------------
package tsos_pkg;

    localparam int SLOTS_DEF        = 64;
    localparam int OPS_PER_SLOT_DEF = 16;
    localparam int OP_BITS_DEF      = 8;

    localparam int FIELD_OP_W = 8;
    localparam int WAIT_W     = 32;
    localparam int TICK_W     = 32;
    localparam int STATUS_W   = 3;
    localparam int KIND_W     = 2;
    localparam int Q_DEPTH    = 2;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_STOPPED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd4;

    typedef enum logic [KIND_W-1:0] {
        K_STATUS,
        K_SCHED,
        K_TICK
    } t_kind;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_FILL,
        S_WALK
    } t_state;

    typedef struct packed {
        logic running;
        logic clearing;
    } t_back_stat;

endpackage

@@ design/tsos_queue.sv @@
// ----------------------------------------------------------------------------
// tsos_queue
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module tsos_queue #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_push_data,
    output logic              o_room,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data,
    input  logic              i_pop
);

    localparam int PTR_W = $clog2(tsos_pkg::Q_DEPTH);
    localparam int CNT_W = $clog2(tsos_pkg::Q_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(tsos_pkg::Q_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(tsos_pkg::Q_DEPTH);

    logic [DATA_W-1:0] r_mem [tsos_pkg::Q_DEPTH];
    logic [PTR_W-1:0]  r_wp, r_rp;
    logic [CNT_W-1:0]  r_cnt;
    logic              do_push, do_pop;

    assign o_room  = (r_cnt != DEPTH_C);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && o_room;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == LAST_PTR) ? '0 : r_wp + PTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == LAST_PTR) ? '0 : r_rp + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

@@ design/tsos_front.sv @@
// ----------------------------------------------------------------------------
// tsos_front
// takes request transfers, sorts out early refusals and queues commands
// ----------------------------------------------------------------------------
module tsos_front #(
    parameter int SLOTS   = tsos_pkg::SLOTS_DEF,
    parameter int OP_BITS = tsos_pkg::OP_BITS_DEF
) (
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  i_req_type,
    input  logic [tsos_pkg::FIELD_OP_W-1:0]       i_op_code,
    input  logic [tsos_pkg::WAIT_W-1:0]           i_wait_ticks,
    input  tsos_pkg::t_back_stat                  i_stat,
    input  logic                                  i_q_room,
    output logic                                  o_push,
    output logic [tsos_pkg::KIND_W + tsos_pkg::STATUS_W
                  + ((OP_BITS < tsos_pkg::FIELD_OP_W) ? OP_BITS : tsos_pkg::FIELD_OP_W)
                  + $clog2(SLOTS) - 1:0]           o_push_data
);

    localparam int OP_W   = (OP_BITS < tsos_pkg::FIELD_OP_W) ? OP_BITS : tsos_pkg::FIELD_OP_W;
    localparam int SLOT_W = $clog2(SLOTS);

    logic                            accept;
    tsos_pkg::t_kind                 kind;
    logic [tsos_pkg::STATUS_W-1:0]   status;
    logic                            wait_ok;

    assign busy    = !i_q_room || i_stat.clearing;
    assign accept  = start && !busy;
    assign wait_ok = (i_wait_ticks < tsos_pkg::WAIT_W'(SLOTS));

    always_comb begin
        kind   = tsos_pkg::K_TICK;
        status = tsos_pkg::ST_OK;
        if (i_req_type) begin
            if (!i_stat.running) begin
                kind   = tsos_pkg::K_STATUS;
                status = tsos_pkg::ST_STOPPED;
            end else if (!wait_ok) begin
                kind   = tsos_pkg::K_STATUS;
                status = tsos_pkg::ST_TOO_LONG;
            end else begin
                kind = tsos_pkg::K_SCHED;
            end
        end
    end

    // a tick while stopped is dropped here
    assign o_push      = accept && (i_req_type || i_stat.running);
    assign o_push_data = {kind, status, i_op_code[OP_W-1:0], i_wait_ticks[SLOT_W-1:0]};

endmodule

@@ design/tsos_back.sv @@
// ----------------------------------------------------------------------------
// tsos_back
// wheel memories, tick counter and the sequencer that runs queued commands
// ----------------------------------------------------------------------------
`include "tick_slot_operation_scheduler_macros.svh"

module tsos_back #(
    parameter int SLOTS        = tsos_pkg::SLOTS_DEF,
    parameter int OPS_PER_SLOT = tsos_pkg::OPS_PER_SLOT_DEF,
    parameter int OP_BITS      = tsos_pkg::OP_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    input  logic                                  i_cfg_data,
    output logic                                  o_cfg_ready,
    input  logic                                  i_q_valid,
    input  logic [tsos_pkg::KIND_W + tsos_pkg::STATUS_W
                  + ((OP_BITS < tsos_pkg::FIELD_OP_W) ? OP_BITS : tsos_pkg::FIELD_OP_W)
                  + $clog2(SLOTS) - 1:0]           i_q_data,
    output logic                                  o_pop,
    output tsos_pkg::t_back_stat                  o_stat,
    output logic                                  o_strobe,
    output logic                                  o_is_fired,
    output logic [tsos_pkg::STATUS_W-1:0]         o_status,
    output logic [tsos_pkg::FIELD_OP_W-1:0]       o_fired_op,
    output logic                                  o_last,
    output logic [tsos_pkg::TICK_W-1:0]           o_tick_now
);

    localparam int OP_W   = (OP_BITS < tsos_pkg::FIELD_OP_W) ? OP_BITS : tsos_pkg::FIELD_OP_W;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(OPS_PER_SLOT + 1);
    localparam int ADDR_W = $clog2(SLOTS * OPS_PER_SLOT);
    localparam int ST_W   = tsos_pkg::STATUS_W;
    localparam int TW     = tsos_pkg::TICK_W;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
    localparam logic [SLOT_W:0]   SLOTS_E   = (SLOT_W + 1)'(SLOTS);
    localparam logic [CNT_W-1:0]  OPS_C     = CNT_W'(OPS_PER_SLOT);
    localparam logic [ADDR_W-1:0] OPS_A     = ADDR_W'(OPS_PER_SLOT);

    // wheel storage
    logic [CNT_W-1:0] r_fill_mem [SLOTS];
    logic [OP_W-1:0]  r_ops_mem  [SLOTS * OPS_PER_SLOT];
    logic [CNT_W-1:0] r_fill_rd;
    logic [OP_W-1:0]  r_op_rd;

    logic              fill_we;
    logic [SLOT_W-1:0] fill_waddr, fill_raddr;
    logic [CNT_W-1:0]  fill_wdata;
    logic              ops_we;
    logic [ADDR_W-1:0] ops_waddr, ops_raddr;
    logic [OP_W-1:0]   ops_wdata;

    tsos_pkg::t_state  r_state, n_state;
    logic              r_running, n_running;
    logic [TW-1:0]     r_tick, n_tick;
    logic [SLOT_W-1:0] r_cur, n_cur;
    logic [SLOT_W-1:0] r_clr, n_clr;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [OP_W-1:0]   r_op, n_op;
    logic              r_is_tick, n_is_tick;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [ADDR_W-1:0] r_base, n_base;

    logic                          r_strobe, n_strobe;
    logic                          r_is_fired, n_is_fired;
    logic [ST_W-1:0]               r_status, n_status;
    logic [OP_W-1:0]               r_out_op, n_out_op;
    logic                          r_last, n_last;
    logic [TW-1:0]                 r_now, n_now;

    logic              cfg_fire;
    logic              cfg_change;
    tsos_pkg::t_kind   h_kind;
    logic [ST_W-1:0]   h_status;
    logic [OP_W-1:0]   h_op;
    logic [SLOT_W-1:0] h_wait;
    logic              tick_pop;

    assign h_wait   = i_q_data[SLOT_W-1:0];
    assign h_op     = i_q_data[SLOT_W +: OP_W];
    assign h_status = i_q_data[SLOT_W + OP_W +: ST_W];
    assign h_kind   = tsos_pkg::t_kind'(i_q_data[SLOT_W + OP_W + ST_W +: tsos_pkg::KIND_W]);

    assign o_cfg_ready = (r_state == tsos_pkg::S_IDLE) || (r_state == tsos_pkg::S_CLEAR);
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign cfg_change  = cfg_fire && (i_cfg_data != r_running);
    assign tick_pop    = o_pop && (h_kind == tsos_pkg::K_TICK);

    assign o_stat.running  = r_running;
    assign o_stat.clearing = (r_state == tsos_pkg::S_CLEAR);

    always_ff @(posedge i_clk) begin
        if (fill_we) begin
            r_fill_mem[fill_waddr] <= fill_wdata;
        end
        r_fill_rd <= r_fill_mem[fill_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (ops_we) begin
            r_ops_mem[ops_waddr] <= ops_wdata;
        end
        r_op_rd <= r_ops_mem[ops_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tsos_pkg::S_CLEAR;
            r_running <= 1'b0;
            r_tick    <= '0;
            r_cur     <= '0;
            r_clr     <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_running <= n_running;
            r_tick    <= n_tick;
            r_cur     <= n_cur;
            r_clr     <= n_clr;
            r_strobe  <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot     <= n_slot;
        r_op       <= n_op;
        r_is_tick  <= n_is_tick;
        r_n        <= n_n;
        r_cnt      <= n_cnt;
        r_base     <= n_base;
        r_is_fired <= n_is_fired;
        r_status   <= n_status;
        r_out_op   <= n_out_op;
        r_last     <= n_last;
        r_now      <= n_now;
    end

    always_comb begin
        logic [SLOT_W:0]   sum;
        logic [CNT_W-1:0]  cnt_inc;
        logic              walk_end;
        logic [ADDR_W-1:0] slot_base;

        sum       = (SLOT_W + 1)'(r_cur) + (SLOT_W + 1)'(h_wait);
        cnt_inc   = r_cnt + CNT_W'(1);
        walk_end  = (cnt_inc == r_n);
        slot_base = ADDR_W'(r_slot) * OPS_A;

        n_state    = r_state;
        n_running  = r_running;
        n_tick     = r_tick;
        n_cur      = r_cur;
        n_clr      = r_clr;
        n_slot     = r_slot;
        n_op       = r_op;
        n_is_tick  = r_is_tick;
        n_n        = r_n;
        n_cnt      = r_cnt;
        n_base     = r_base;
        n_strobe   = 1'b0;
        n_is_fired = 1'b0;
        n_status   = tsos_pkg::ST_OK;
        n_out_op   = '0;
        n_last     = 1'b1;
        n_now      = r_tick;
        o_pop      = 1'b0;
        fill_we    = 1'b0;
        fill_waddr = r_slot;
        fill_wdata = '0;
        fill_raddr = r_cur;
        ops_we     = 1'b0;
        ops_waddr  = r_base;
        ops_wdata  = r_op;
        ops_raddr  = r_base;

        unique case (r_state)
            tsos_pkg::S_CLEAR: begin
                fill_we    = 1'b1;
                fill_waddr = r_clr;
                if (cfg_change) begin
                    n_running = i_cfg_data;
                    n_clr     = '0;
                end else if (r_clr == LAST_SLOT) begin
                    n_state = tsos_pkg::S_IDLE;
                end else begin
                    n_clr = r_clr + SLOT_W'(1);
                end
            end
            tsos_pkg::S_IDLE: begin
                if (cfg_change) begin
                    n_running = i_cfg_data;
                    n_tick    = '0;
                    n_cur     = '0;
                    n_clr     = '0;
                    n_state   = tsos_pkg::S_CLEAR;
                end else if (!cfg_fire && i_q_valid) begin
                    o_pop = 1'b1;
                    unique case (h_kind)
                        tsos_pkg::K_STATUS: begin
                            n_strobe = 1'b1;
                            n_status = h_status;
                        end
                        tsos_pkg::K_SCHED: begin
                            n_slot     = (sum >= SLOTS_E) ? SLOT_W'(sum - SLOTS_E)
                                                          : SLOT_W'(sum);
                            fill_raddr = n_slot;
                            n_op       = h_op;
                            n_is_tick  = 1'b0;
                            n_state    = tsos_pkg::S_FILL;
                        end
                        tsos_pkg::K_TICK: begin
                            n_slot    = r_cur;
                            n_tick    = r_tick + TW'(1);
                            n_cur     = (r_cur == LAST_SLOT) ? '0 : r_cur + SLOT_W'(1);
                            n_is_tick = 1'b1;
                            n_state   = tsos_pkg::S_FILL;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            tsos_pkg::S_FILL: begin
                n_n       = r_fill_rd;
                n_cnt     = '0;
                n_base    = slot_base;
                ops_raddr = slot_base;
                if (r_is_tick) begin
                    fill_we = 1'b1;
                    n_state = (r_fill_rd == '0) ? tsos_pkg::S_IDLE : tsos_pkg::S_WALK;
                end else if (r_fill_rd == '0) begin
                    ops_we     = 1'b1;
                    ops_waddr  = slot_base;
                    fill_we    = 1'b1;
                    fill_wdata = CNT_W'(1);
                    n_strobe   = 1'b1;
                    n_state    = tsos_pkg::S_IDLE;
                end else begin
                    n_state = tsos_pkg::S_WALK;
                end
            end
            tsos_pkg::S_WALK: begin
                ops_raddr = r_base + ADDR_W'(cnt_inc);
                if (r_is_tick) begin
                    n_strobe   = 1'b1;
                    n_is_fired = 1'b1;
                    n_out_op   = r_op_rd;
                    n_last     = walk_end;
                    if (walk_end) begin
                        n_state = tsos_pkg::S_IDLE;
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end else if (r_op_rd == r_op) begin
                    n_strobe = 1'b1;
                    n_status = tsos_pkg::ST_DUPLICATE;
                    n_state  = tsos_pkg::S_IDLE;
                end else if (walk_end) begin
                    n_strobe = 1'b1;
                    n_state  = tsos_pkg::S_IDLE;
                    if (r_n == OPS_C) begin
                        n_status = tsos_pkg::ST_FULL;
                    end else begin
                        ops_we     = 1'b1;
                        ops_waddr  = r_base + ADDR_W'(r_n);
                        fill_we    = 1'b1;
                        fill_wdata = r_n + CNT_W'(1);
                    end
                end else begin
                    n_cnt = cnt_inc;
                end
            end
        endcase
    end

    assign o_strobe   = r_strobe;
    assign o_is_fired = r_is_fired;
    assign o_status   = r_status;
    assign o_fired_op = tsos_pkg::FIELD_OP_W'(r_out_op);
    assign o_last     = r_last;
    assign o_tick_now = r_now;

    `TSOS_ASSERT(a_status_last, (o_strobe && !o_is_fired) |-> o_last, "status result not last")
    `TSOS_ASSERT(a_fired_run, (o_strobe && o_is_fired && !o_last) |=> (o_strobe && o_is_fired), "fired run broken")
    `TSOS_ASSERT(a_tick_adv, tick_pop |=> (r_tick == $past(r_tick) + TW'(1)), "tick counter did not advance")
    `TSOS_ASSERT(a_fill_bound, fill_we |-> (fill_wdata <= OPS_C), "slot fill above capacity")
    `TSOS_ASSERT_ALWAYS(a_clear_busy, (r_state == tsos_pkg::S_CLEAR) |-> (o_stat.clearing && !o_pop), "command taken while clearing")

endmodule

@@ design/tick_slot_operation_scheduler.sv @@
// ----------------------------------------------------------------------------
// tick_slot_operation_scheduler
// timer wheel that schedules operation codes and fires them on ticks
//
//  channel   | handshake                | payload
//  ----------+--------------------------+--------------------------------------
//  request   | start / busy             | i_req_type i_op_code i_wait_ticks
//  result    | o_strobe (one cycle)     | o_is_fired o_status o_fired_op o_last
//            |                          | o_tick_now
//  config    | i_cfg_valid / o_cfg_ready| i_cfg_data (running)
//
//  a refused schedule is answered from the idle state alone, a tick passes the fill
//  state and then walks its n fired ops, a schedule passes the fill state (slot scan)
//  a two entry command queue lets requests transfer while the sequencer works
//  after reset and on each change of running a clearing pass runs over the fill
//  memory with busy high
//  results leave one per cycle and cannot be held off
// ----------------------------------------------------------------------------
module tick_slot_operation_scheduler #(
    parameter int SLOTS        = tsos_pkg::SLOTS_DEF,
    parameter int OPS_PER_SLOT = tsos_pkg::OPS_PER_SLOT_DEF,
    parameter int OP_BITS      = tsos_pkg::OP_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_req_type,
    input  logic [tsos_pkg::FIELD_OP_W-1:0] i_op_code,
    input  logic [tsos_pkg::WAIT_W-1:0]     i_wait_ticks,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic                            i_cfg_data,
    output logic                            o_strobe,
    output logic                            o_is_fired,
    output logic [tsos_pkg::STATUS_W-1:0]   o_status,
    output logic [tsos_pkg::FIELD_OP_W-1:0] o_fired_op,
    output logic                            o_last,
    output logic [tsos_pkg::TICK_W-1:0]     o_tick_now
);

    localparam int OP_W   = (OP_BITS < tsos_pkg::FIELD_OP_W) ? OP_BITS : tsos_pkg::FIELD_OP_W;
    localparam int DATA_W = tsos_pkg::KIND_W + tsos_pkg::STATUS_W + OP_W + $clog2(SLOTS);

    tsos_pkg::t_back_stat stat;
    logic                 q_room, q_push, q_valid, q_pop;
    logic [DATA_W-1:0]    q_push_data, q_data;

    tsos_front #(
        .SLOTS   (SLOTS),
        .OP_BITS (OP_BITS)
    ) u_front (
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_op_code    (i_op_code),
        .i_wait_ticks (i_wait_ticks),
        .i_stat       (stat),
        .i_q_room     (q_room),
        .o_push       (q_push),
        .o_push_data  (q_push_data)
    );

    tsos_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_room      (q_room),
        .o_valid     (q_valid),
        .o_data      (q_data),
        .i_pop       (q_pop)
    );

    tsos_back #(
        .SLOTS        (SLOTS),
        .OPS_PER_SLOT (OPS_PER_SLOT),
        .OP_BITS      (OP_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_q_valid   (q_valid),
        .i_q_data    (q_data),
        .o_pop       (q_pop),
        .o_stat      (stat),
        .o_strobe    (o_strobe),
        .o_is_fired  (o_is_fired),
        .o_status    (o_status),
        .o_fired_op  (o_fired_op),
        .o_last      (o_last),
        .o_tick_now  (o_tick_now)
    );

endmodule
